// ----- sv/hashed_multiway_index_memory_defines.svh -----
// assertion macros used by the checker file of the hashed index memory
// no dependencies; expects clk and arst_n in the scope of each use
`ifndef HASHED_MULTIWAY_INDEX_MEMORY_DEFINES_SVH
`define HASHED_MULTIWAY_INDEX_MEMORY_DEFINES_SVH

// property checked on every clock edge outside reset
`define HMIM_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define HMIM_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/hmim_pkg.sv -----
// shared types, codes and default sizes of the hashed index memory
// used by every module of the block but hmim_ram and the checker; no dependencies
`timescale 1ns / 1ps

package hmim_pkg;

	localparam int BUCKETS_DEF  = 256;
	localparam int WAYS_DEF     = 4;
	localparam int KEY_BITS_DEF = 32;

	localparam int KIND_W      = 2;
	localparam int KEY_W       = 32;
	localparam int DATA_W      = 32;
	localparam int HASH_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int NUM_ROWREGS = 4;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_STORE = 2'd1,
		OP_INIT  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_A = 3'd0,
		REG_ROWS_B = 3'd1,
		REG_ROWS_C = 3'd2,
		REG_ROWS_D = 3'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} bk_state_t;

	// one classified operation waiting for the back end
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
		logic [HASH_W-1:0] code;
	} item_t;

	typedef struct packed {
		logic                  empty;
		logic [FIFO_CNT_W-1:0] count;
	} fifo_stat_t;

endpackage

// ----- sv/hmim_ram.sv -----
// generic single-port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module hmim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/hmim_front.sv -----
// front end: hash matrix registers, item capture and h3 set hashing
// depends on hmim_pkg; feeds hmim_fifo
`timescale 1ns / 1ps

module hmim_front #(
	parameter int KEY_BITS = hmim_pkg::KEY_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [hmim_pkg::KIND_W-1:0]      kind,
	input  logic [hmim_pkg::KEY_W-1:0]       key,
	input  logic [hmim_pkg::DATA_W-1:0]      data_in,
	input  logic                             cfg_we,
	input  logic [hmim_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hmim_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             hold,
	input  hmim_pkg::fifo_stat_t             fifo_stat,
	output logic                             busy,
	output logic                             push,
	output hmim_pkg::item_t                  item
);

	import hmim_pkg::*;

	localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 64'd1);

	logic [NUM_ROWREGS-1:0][CFG_DATA_W-1:0] hash_rows_q;
	logic                                   vld_s1;
	logic [KIND_W-1:0]                      kind_s1;
	logic [KEY_W-1:0]                       key_s1;
	logic [DATA_W-1:0]                      data_s1;
	logic [HASH_W-1:0]                      code;
	logic [FIFO_CNT_W:0]                    in_use;
	logic                                   accept;

	// entries already queued plus the one in the capture stage
	assign in_use = {1'b0, fifo_stat.count} + (FIFO_CNT_W + 1)'(vld_s1);
	assign busy   = hold || (in_use >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_rows_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_A: hash_rows_q[0] <= cfg_data;
				REG_ROWS_B: hash_rows_q[1] <= cfg_data;
				REG_ROWS_C: hash_rows_q[2] <= cfg_data;
				REG_ROWS_D: hash_rows_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			key_s1  <= key & KEY_MASK;
			data_s1 <= data_in;
		end
	end

	// h3: xor of the matrix rows picked by the set key bits
	always_comb begin
		code = '0;
		for (int i = 0; i < KEY_BITS; i++) begin
			if (key_s1[i]) begin
				code = code ^ hash_rows_q[i >> 3][(i & 7) * HASH_W +: HASH_W];
			end
		end
	end

	assign push      = vld_s1;
	assign item.kind = kind_s1;
	assign item.key  = key_s1;
	assign item.data = data_s1;
	assign item.code = code;

endmodule

// ----- sv/hmim_fifo.sv -----
// short queue of hashed operations between front and back end
// depends on hmim_pkg
`timescale 1ns / 1ps

module hmim_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hmim_pkg::item_t      push_item,
	input  logic                 pop,
	output hmim_pkg::item_t      head,
	output hmim_pkg::fifo_stat_t stat
);

	import hmim_pkg::*;

	item_t                 slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	assign head       = slot_q[rd_q];
	assign stat.count = cnt_q;
	assign stat.empty = (cnt_q == '0);

endmodule

// ----- sv/hmim_back.sv -----
// back end: reset clearing pass, set read, way scan, row write-back, result and overflow flag
// depends on hmim_pkg and hmim_ram; fed by hmim_fifo
`timescale 1ns / 1ps

module hmim_back #(
	parameter int BUCKETS  = hmim_pkg::BUCKETS_DEF,
	parameter int WAYS     = hmim_pkg::WAYS_DEF,
	parameter int KEY_BITS = hmim_pkg::KEY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hmim_pkg::fifo_stat_t         fifo_stat,
	input  hmim_pkg::item_t              head,
	output logic                         pop,
	output logic                         clearing,
	output logic                         done,
	output logic                         found,
	output logic [hmim_pkg::DATA_W-1:0]  data_out,
	output logic                         no_room,
	output logic                         overflow_seen
);

	import hmim_pkg::*;

	localparam int SET_W     = $clog2(BUCKETS);
	localparam int EXT_W     = (SET_W > HASH_W) ? SET_W : HASH_W;
	localparam int WAY_W     = 1 + KEY_BITS + DATA_W;
	localparam int ROW_W     = WAYS * WAY_W;
	localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(BUCKETS - 1);

	bk_state_t         state_q, state_d;
	logic [SET_W-1:0]  clr_q;
	item_t             cur_q;
	logic [SET_W-1:0]  set_q;
	logic              done_q, found_q, no_room_q, ovf_q;
	logic [DATA_W-1:0] data_out_q;

	logic [EXT_W-1:0]  head_ext;
	logic [SET_W-1:0]  head_set;
	logic              ram_we;
	logic [SET_W-1:0]  ram_addr;
	logic [ROW_W-1:0]  ram_wdata, ram_rdata;

	logic [WAYS-1:0]      vld, keq, cand;
	logic                 hit;
	logic [WAY_IDX_W-1:0] sel;
	logic [DATA_W-1:0]    sel_data;
	logic [ROW_W-1:0]     new_row;
	logic                 is_load, is_write;

	// set is the hash masked to the table size
	assign head_ext = EXT_W'(head.code);
	assign head_set = head_ext[SET_W-1:0];

	assign is_load  = (cur_q.kind == OP_LOAD);
	assign is_write = (cur_q.kind == OP_STORE) || (cur_q.kind == OP_INIT);

	hmim_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// way scan over the row read from the set
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			vld[w] = ram_rdata[w * WAY_W + WAY_W - 1];
			keq[w] = (ram_rdata[w * WAY_W + DATA_W +: KEY_BITS] == cur_q.key[KEY_BITS-1:0]);
		end
		case (cur_q.kind)
			OP_LOAD:  cand = vld & keq;
			OP_STORE: cand = ~vld | keq;
			OP_INIT:  cand = ~vld;
			default:  cand = '0;
		endcase
		hit = 1'b0;
		sel = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (cand[w]) begin
				hit = 1'b1;
				sel = WAY_IDX_W'(w);
			end
		end
		sel_data = '0;
		new_row  = ram_rdata;
		for (int w = 0; w < WAYS; w++) begin
			if (sel == WAY_IDX_W'(w)) begin
				sel_data = ram_rdata[w * WAY_W +: DATA_W];
				new_row[w * WAY_W +: WAY_W] = {1'b1, cur_q.key[KEY_BITS-1:0], cur_q.data};
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = head_set;
		ram_wdata = new_row;
		pop       = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
				if (clr_q == LAST_SET) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!fifo_stat.empty) begin
					pop     = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				ram_addr = set_q;
				ram_we   = is_write && hit;
				state_d  = BK_IDLE;
			end
			default: begin
				state_d = BK_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			found_q    <= 1'b0;
			no_room_q  <= 1'b0;
			data_out_q <= '0;
			ovf_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == BK_EXEC);
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == BK_EXEC) begin
				found_q    <= is_load && hit;
				data_out_q <= (is_load && hit) ? sel_data : '0;
				no_room_q  <= is_write && !hit;
				if (is_write && !hit) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
			set_q <= head_set;
		end
	end

	assign clearing      = (state_q == BK_CLEAR);
	assign done          = done_q;
	assign found         = found_q;
	assign data_out      = data_out_q;
	assign no_room       = no_room_q;
	assign overflow_seen = ovf_q;

endmodule

// ----- sv/hashed_multiway_index_memory.sv -----
// top level of the h3-hashed set-associative key/value table
// depends on hmim_pkg, hmim_front, hmim_fifo, hmim_back (and hmim_ram below it)
`timescale 1ns / 1ps

// Usage
// - command channel: an operation (kind, key, data_in) is taken at a rising edge with
//   start high and busy low. kind 0 loads, 1 stores or updates, 2 places only in a free way.
// - result: done is high for exactly one cycle per operation with found, data_out, no_room
//   and overflow_seen; the receiver cannot hold it off and always takes it.
// - path: on an empty block an accepted operation passes the capture register, the queue,
//   the back end's idle state (pop, set read) and its exec state; done is registered from exec.
// - back end: it handles one operation at a time, a read-modify-write of one set row through
//   the single ram port (set read in idle, scan and write back in exec).
// - a four-entry queue plus a capture stage sits between front and back; busy is high during
//   clearing or when the two hold four in all, else low, so short bursts go one per cycle.
// - configuration: cfg_valid/cfg_ready write a 64-bit hash matrix register by cfg_index
//   (0..3); cfg_ready is always high, other indexes are ignored. Write only when idle.
// - reset: hash registers and the overflow flag clear; then a clearing pass writes every
//   set row once, with busy high. Configuration writes are taken meanwhile.
module hashed_multiway_index_memory #(
	parameter int BUCKETS  = hmim_pkg::BUCKETS_DEF,
	parameter int WAYS     = hmim_pkg::WAYS_DEF,
	parameter int KEY_BITS = hmim_pkg::KEY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [hmim_pkg::KIND_W-1:0]     kind,
	input  logic [hmim_pkg::KEY_W-1:0]      key,
	input  logic [hmim_pkg::DATA_W-1:0]     data_in,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hmim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hmim_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            done,
	output logic                            found,
	output logic [hmim_pkg::DATA_W-1:0]     data_out,
	output logic                            no_room,
	output logic                            overflow_seen
);

	import hmim_pkg::*;

	item_t      push_item, head;
	fifo_stat_t fifo_stat;
	logic       push, pop, clearing;

	assign cfg_ready = 1'b1;

	hmim_front #(
		.KEY_BITS (KEY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.key       (key),
		.data_in   (data_in),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.hold      (clearing),
		.fifo_stat (fifo_stat),
		.busy      (busy),
		.push      (push),
		.item      (push_item)
	);

	hmim_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	hmim_back #(
		.BUCKETS  (BUCKETS),
		.WAYS     (WAYS),
		.KEY_BITS (KEY_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_stat     (fifo_stat),
		.head          (head),
		.pop           (pop),
		.clearing      (clearing),
		.done          (done),
		.found         (found),
		.data_out      (data_out),
		.no_room       (no_room),
		.overflow_seen (overflow_seen)
	);

endmodule

// ----- sv/hmim_checker.sv -----
// port-level checks on the result channel of the hashed index memory
// depends on hashed_multiway_index_memory_defines.svh; bound to the top level
`timescale 1ns / 1ps
`include "hashed_multiway_index_memory_defines.svh"

module hmim_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic        found,
	input logic [31:0] data_out,
	input logic        no_room,
	input logic        overflow_seen
);

	// the back end handles one transaction at a time, so result strobes never come back to back
	`HMIM_CHECK(a_done_spacing, done |=> !done, "result strobes in back-to-back cycles")
	`HMIM_CHECK(a_hit_excl, done |-> !(found && no_room), "load hit and no_room together")
	`HMIM_CHECK(a_miss_zero, (done && !found) |-> (data_out == '0), "nonzero data without hit")
	`HMIM_CHECK(a_ovf_sticky, overflow_seen |=> overflow_seen, "overflow flag dropped")
	`HMIM_CHECK_ALWAYS(a_room_flag, (done && no_room) |-> overflow_seen, "no_room without flag")

endmodule

bind hashed_multiway_index_memory hmim_checker u_hmim_checker (.*);

// ----- verif/tb_hashed_multiway_index_memory.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the h3-hashed set-associative key/value table
// depends on hmim_pkg and hashed_multiway_index_memory; keeps its own mirror of table and hash rows

module tb_hashed_multiway_index_memory;

	import hmim_pkg::*;

	localparam int NSETS          = BUCKETS_DEF;
	localparam int NWAYS          = WAYS_DEF;
	localparam int NKEYBITS       = KEY_BITS_DEF;
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - NKEYBITS);
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int POOL_SIZE      = 24;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] data_out;
		logic              no_room;
		logic              overflow_seen;
	} outcome_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [KIND_W-1:0]     kind;
	logic [KEY_W-1:0]      key;
	logic [DATA_W-1:0]     data_in;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  done;
	logic                  found;
	logic [DATA_W-1:0]     data_out;
	logic                  no_room;
	logic                  overflow_seen;

	// mirror of the table, the hash rows and the sticky flag
	bit [CFG_DATA_W-1:0] row_mirror [NUM_ROWREGS];
	bit                  tbl_valid  [NWAYS][NSETS];
	bit [KEY_W-1:0]      tbl_key    [NWAYS][NSETS];
	bit [DATA_W-1:0]     tbl_data   [NWAYS][NSETS];
	bit                  overflow_mirror;

	outcome_t        pending_outcomes [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int              fail_count;
	int              quiet_cycles;

	hashed_multiway_index_memory #(
		.BUCKETS  (NSETS),
		.WAYS     (NWAYS),
		.KEY_BITS (NKEYBITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.key           (key),
		.data_in       (data_in),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.found         (found),
		.data_out      (data_out),
		.no_room       (no_room),
		.overflow_seen (overflow_seen)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [HASH_W-1:0] h3_code(input logic [KEY_W-1:0] k);
		logic [HASH_W-1:0] h;
		h = '0;
		for (int i = 0; i < NKEYBITS; i++)
			if (k[i])
				h ^= row_mirror[i / 8][(i % 8) * HASH_W +: HASH_W];
		return h;
	endfunction

	// apply one operation to the mirror table and return what the block must report
	function automatic outcome_t run_table_op(input logic [KIND_W-1:0] op,
			input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] d);
		outcome_t res;
		logic [KEY_W-1:0] km;
		int set_idx;
		bit placed;
		res = '0;
		placed = 1'b0;
		km = k & KEY_MASK;
		set_idx = int'(h3_code(km)) & (NSETS - 1);
		case (op)
			OP_LOAD: begin
				for (int w = 0; w < NWAYS; w++)
					if (!res.found && tbl_valid[w][set_idx] && tbl_key[w][set_idx] == km) begin
						res.found = 1'b1;
						res.data_out = tbl_data[w][set_idx];
					end
			end
			OP_STORE, OP_INIT: begin
				for (int w = 0; w < NWAYS; w++)
					if (!placed && (!tbl_valid[w][set_idx] ||
							(op == OP_STORE && tbl_key[w][set_idx] == km))) begin
						tbl_valid[w][set_idx] = 1'b1;
						tbl_key[w][set_idx] = km;
						tbl_data[w][set_idx] = d;
						placed = 1'b1;
					end
				if (!placed) begin
					res.no_room = 1'b1;
					overflow_mirror = 1'b1;
				end
			end
			default: ;
		endcase
		res.overflow_seen = overflow_mirror;
		return res;
	endfunction

	task automatic report_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// results first, then register writes, then newly accepted operations
	always @(posedge clk) begin : track_transactions
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result, expected none, got found %b data_out %h",
					$time, found, data_out);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				report_field("found", want.found, found);
				report_field("data_out", want.data_out, data_out);
				report_field("no_room", want.no_room, no_room);
				report_field("overflow_seen", want.overflow_seen, overflow_seen);
			end
		end
		if (arst_n && cfg_valid && cfg_ready && cfg_index < NUM_ROWREGS)
			row_mirror[cfg_index] = cfg_data;
		if (arst_n && start && !busy)
			pending_outcomes.push_back(run_table_op(kind, key, data_in));
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// each row byte is masked, so a narrow mask crowds keys into few sets
	task automatic configure_rows(input logic [HASH_W-1:0] mask, input bit scramble);
		logic [CFG_DATA_W-1:0] v [NUM_ROWREGS];
		for (int r = 0; r < NUM_ROWREGS; r++)
			v[r] = (scramble ? {$urandom(), $urandom()} : {CFG_DATA_W{1'b1}}) & {8{mask}};
		write_reg(REG_ROWS_A, v[0]);
		write_reg(REG_ROWS_B, v[1]);
		write_reg(REG_ROWS_C, v[2]);
		write_reg(REG_ROWS_D, v[3]);
	endtask

	// start stays high after acceptance; the next call or settle_idle changes it
	task automatic issue_op(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] kv,
			input logic [DATA_W-1:0] dv, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		kind <= k;
		key <= kv;
		data_in <= dv;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return OP_LOAD;
		if (r < 70)
			return OP_STORE;
		if (r < 93)
			return OP_INIT;
		return KIND_UNUSED;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 84)
			return '0;
		if (r < 88)
			return '1;
		return $urandom();
	endfunction

	// mostly pool keys so loads hit and stores update; a dense stretch every 40 ops
	task automatic random_traffic(input int n_ops);
		for (int i = 0; i < POOL_SIZE; i += 2)
			key_pool[i] = $urandom();
		for (int i = 0; i < n_ops; i++)
			issue_op(pick_kind(), pick_key(), $urandom(), ((i % 40) < 12) ? 0 : pick_gap());
		settle_idle();
	endtask

	// zero matrix: every key lands in set 0, so its ways fill and overflow
	task automatic test_same_set_fill();
		configure_rows(8'h00, 1'b0);
		issue_op(OP_LOAD,  32'h0000_0000, 32'hDEAD_BEEF, 0);
		issue_op(OP_STORE, 32'h0000_0000, 32'h0000_0000, 0);
		issue_op(OP_LOAD,  32'h0000_0000, 32'h0000_0000, 1);
		issue_op(OP_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		issue_op(OP_LOAD,  32'hFFFF_FFFF, 32'h0000_0000, 5);
		issue_op(OP_STORE, 32'h0000_0000, 32'h5A5A_5A5A, 0);
		// init ignores the existing match and takes the next free way
		issue_op(OP_INIT,  32'h0000_0000, 32'hA5A5_A5A5, 0);
		issue_op(OP_LOAD,  32'h0000_0000, 32'h0000_0000, 2);
		issue_op(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		issue_op(OP_INIT,  32'h1234_5678, 32'hC3C3_C3C3, 0);
		issue_op(OP_INIT,  32'h0000_0001, 32'h0000_0001, 0);
		issue_op(OP_STORE, 32'h0000_0002, 32'h0000_0002, 3);
		issue_op(OP_STORE, 32'hFFFF_FFFF, 32'h0000_0000, 0);
		issue_op(OP_LOAD,  32'h0000_0002, 32'h0000_0000, 0);
		settle_idle();
	endtask

	task automatic test_unused_registers();
		for (int r = NUM_ROWREGS; r < 2 ** CFG_IDX_W; r++)
			write_reg(CFG_IDX_W'(r), {$urandom(), $urandom()});
		issue_op(OP_LOAD, 32'h1234_5678, 32'h0000_0000, 0);
		issue_op(OP_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, 0);
		issue_op(KIND_UNUSED, 32'h0000_0000, 32'h0000_0000, 1);
		settle_idle();
	endtask

	task automatic test_hash_extremes();
		// all-ones rows: the code is the key parity on every bit, set 0 or the last set
		configure_rows(8'hFF, 1'b0);
		issue_op(OP_STORE, 32'h0000_0001, 32'h1111_1111, 0);
		issue_op(OP_STORE, 32'h0000_0003, 32'h3333_3333, 0);
		issue_op(OP_LOAD,  32'h0000_0001, 32'h0000_0000, 0);
		issue_op(OP_LOAD,  32'h0000_0003, 32'h0000_0000, 2);
		settle_idle();
		// one bit per row: the code is the xor of the key bytes
		write_reg(REG_ROWS_A, 64'h8040_2010_0804_0201);
		write_reg(REG_ROWS_B, 64'h8040_2010_0804_0201);
		write_reg(REG_ROWS_C, 64'h8040_2010_0804_0201);
		write_reg(REG_ROWS_D, 64'h8040_2010_0804_0201);
		issue_op(OP_INIT, 32'h8000_0000, 32'h8765_4321, 0);
		issue_op(OP_LOAD, 32'h8000_0000, 32'h0000_0000, 0);
		settle_idle();
	endtask

	task automatic test_spread_hash();
		configure_rows(8'hFF, 1'b1);
		random_traffic(140);
	endtask

	task automatic test_crowded_sets();
		configure_rows(8'h03, 1'b1);
		random_traffic(140);
	endtask

	task automatic test_two_sets();
		configure_rows(8'h01, 1'b1);
		random_traffic(100);
	endtask

	task automatic test_parity_hash();
		configure_rows(8'hFF, 1'b0);
		random_traffic(80);
	endtask

	task automatic test_fresh_matrix();
		configure_rows(8'hFF, 1'b1);
		random_traffic(140);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = OP_LOAD;
		key = '0;
		data_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROWS_A;
		cfg_data = '0;
		fail_count = 0;
		quiet_cycles = 0;
		overflow_mirror = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_same_set_fill();
		test_unused_registers();
		test_hash_extremes();
		test_spread_hash();
		test_crowded_sets();
		test_two_sets();
		test_parity_hash();
		test_fresh_matrix();

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
